FILE: rtl/core/lzo_pkg.sv
package lzo_pkg;

  typedef enum logic [3:0] {
    PH_FIRST,
    PH_OUTER,
    PH_INSTR,
    PH_LENEXT,
    PH_LITERALS,
    PH_OFF1,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_COPY,
    PH_TRAIL
  } phase_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_RUN  = 2'd0;
  localparam status_t ST_DONE = 2'd1;
  localparam status_t ST_ERR  = 2'd2;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] packed_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    status_t    status;
  } out_item_t;

endpackage

FILE: rtl/core/lzo1x_decompressor_top.sv
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid / in_ready  | lzo_pkg::in_item_t  (command, byte, last)
// out     | output    | out_valid / out_ready| lzo_pkg::out_item_t (byte, pending, status)
//
// One result word per input word; one word per cycle sustained while out_ready stays high.
// The decoder state updates on accept; the result sits in one output register.
// A copied byte comes from the history RAM registered read, issued on accept; a
// distance-one copy is forwarded from the byte written as the previous word leaves.
// History is written when a result word leaves, so a stall holds the write back.
// Reset (synchronous, active low) clears control state; history is not cleared.
// in_ready drops only while the output register is full and out_ready is low.
module lzo1x_decompressor_top #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int LENGTH_BITS   = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lzo_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lzo_pkg::out_item_t out_data
);
  import lzo_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int PW = $clog2(HISTORY_DEPTH + 1);
  localparam int LB = LENGTH_BITS;

  // decoder state
  logic [AW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    instr_r, instr_nxt;
  logic [LB-1:0] run_r, run_nxt;
  logic [15:0]   dist_r, dist_nxt;
  logic [1:0]    trail_r, trail_nxt;
  logic          after_r, after_nxt;
  logic          fin_r, fin_nxt;
  logic          fail_r, fail_nxt;

  // output register
  logic          s1_valid_r;
  logic          s1_ov_r, s1_ov_nxt;
  logic [7:0]    s1_lit_r, s1_lit_nxt;
  logic          s1_mem_r, s1_mem_nxt;
  logic          s1_fwd_r, s1_fwd_nxt;
  logic          s1_wr_r, s1_wr_nxt;
  logic [AW-1:0] s1_addr_r;
  logic          s1_pend_r;
  status_t       s1_stat_r;
  logic [7:0]    last_wr_r;

  logic          accept, leave;
  logic [AW-1:0] rd_idx;
  logic [7:0]    rdata, s1_byte;
  logic          emit;

  assign in_ready = !s1_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign leave    = s1_valid_r && out_ready;

  // history read address for a pull: write pointer minus distance, wrapped
  always_comb begin
    logic [AW:0] w, d;
    w = {1'b0, wp_r};
    d = (AW+1)'(dist_r);
    if (w >= d) rd_idx = AW'(w - d);
    else        rd_idx = AW'(w + (AW+1)'(HISTORY_DEPTH) - d);
  end

  always_comb begin
    logic [LB:0]   tot;
    logic [16:0]   dcopy;
    logic          do_copy;
    logic [15:0]   word;
    logic [16:0]   dm4;
    logic [7:0]    b;
    logic          last;
    wp_nxt    = wp_r;
    prod_nxt  = prod_r;
    phase_nxt = phase_r;
    instr_nxt = instr_r;
    run_nxt   = run_r;
    dist_nxt  = dist_r;
    trail_nxt = trail_r;
    after_nxt = after_r;
    fin_nxt   = fin_r;
    fail_nxt  = fail_r;
    emit       = 1'b0;
    s1_mem_nxt = 1'b0;
    tot        = '0;
    dcopy      = '0;
    do_copy    = 1'b0;
    word       = '0;
    dm4        = '0;
    b          = in_data.packed_byte;
    last       = in_data.last_byte;

    if (!fin_r && !fail_r) begin
      if (in_data.command == CMD_PULL) begin
        if (phase_r == PH_COPY) begin
          emit       = 1'b1;
          s1_mem_nxt = 1'b1;
          if (run_r != '0) run_nxt = run_r - LB'(1);
          if (run_nxt == '0) begin
            after_nxt = 1'b0;
            phase_nxt = (trail_r == 2'd0) ? PH_OUTER : PH_TRAIL;
          end
        end
      end else if (phase_r == PH_COPY) begin
        fail_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_FIRST, PH_OUTER, PH_INSTR: begin
            if (phase_r == PH_FIRST && b > 8'd17) begin
              after_nxt = 1'b0;
              if (b - 8'd17 < 8'd4) begin
                trail_nxt = 2'(b - 8'd17);
                phase_nxt = PH_TRAIL;
              end else begin
                run_nxt   = LB'(b - 8'd17);
                phase_nxt = PH_LITERALS;
              end
            end else begin
              instr_nxt = b;
              if (b >= 8'd64) begin
                phase_nxt = PH_OFF1;
              end else if (b >= 8'd32) begin
                if (b[4:0] == 5'd0) begin
                  run_nxt = '0; phase_nxt = PH_LENEXT;
                end else begin
                  run_nxt = LB'(b[4:0]) + LB'(2); phase_nxt = PH_OFF_LO;
                end
              end else if (b >= 8'd16) begin
                if (b[2:0] == 3'd0) begin
                  run_nxt = '0; phase_nxt = PH_LENEXT;
                end else begin
                  run_nxt = LB'(b[2:0]) + LB'(2); phase_nxt = PH_OFF_LO;
                end
              end else if (phase_r != PH_INSTR) begin
                if (b == 8'd0) begin
                  run_nxt = '0; phase_nxt = PH_LENEXT;
                end else begin
                  run_nxt = LB'(b) + LB'(3); phase_nxt = PH_LITERALS;
                end
              end else begin
                phase_nxt = PH_OFF1;
              end
            end
          end
          PH_LENEXT: begin
            if (b == 8'd0) begin
              tot = {1'b0, run_r} + (LB+1)'(255);
              if (tot[LB]) fail_nxt = 1'b1;
              else run_nxt = tot[LB-1:0];
            end else begin
              if (instr_r < 8'd16) begin
                tot = {1'b0, run_r} + (LB+1)'(b) + (LB+1)'(18);
                phase_nxt = PH_LITERALS;
              end else if (instr_r >= 8'd32) begin
                tot = {1'b0, run_r} + (LB+1)'(b) + (LB+1)'(33);
                phase_nxt = PH_OFF_LO;
              end else begin
                tot = {1'b0, run_r} + (LB+1)'(b) + (LB+1)'(9);
                phase_nxt = PH_OFF_LO;
              end
              if (tot[LB]) begin
                fail_nxt  = 1'b1;
                phase_nxt = phase_r;
              end else begin
                run_nxt = tot[LB-1:0];
              end
            end
          end
          PH_LITERALS, PH_TRAIL: begin
            if (last) begin
              fail_nxt = 1'b1;
            end else begin
              emit = 1'b1;
              if (phase_r == PH_LITERALS) begin
                if (run_r != '0) run_nxt = run_r - LB'(1);
                if (run_nxt == '0) begin
                  after_nxt = 1'b1; phase_nxt = PH_INSTR;
                end
              end else begin
                if (trail_r != 2'd0) trail_nxt = trail_r - 2'd1;
                if (trail_nxt == 2'd0) begin
                  after_nxt = 1'b0; phase_nxt = PH_INSTR;
                end
              end
            end
          end
          PH_OFF1: begin
            trail_nxt = instr_r[1:0];
            do_copy   = 1'b1;
            if (instr_r >= 8'd64) begin
              run_nxt = LB'(instr_r[7:5]) + LB'(1);
              dcopy   = 17'd1 + 17'(instr_r[4:2]) + {6'd0, b, 3'd0};
            end else if (after_r) begin
              run_nxt = LB'(3);
              dcopy   = 17'h0801 + 17'(instr_r[7:2]) + {7'd0, b, 2'd0};
            end else begin
              run_nxt = LB'(2);
              dcopy   = 17'd1 + 17'(instr_r[7:2]) + {7'd0, b, 2'd0};
            end
          end
          PH_OFF_LO: begin
            dist_nxt  = {8'd0, b};
            trail_nxt = b[1:0];
            phase_nxt = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            word = {b, dist_r[7:0]};
            if (instr_r >= 8'd32) begin
              do_copy = 1'b1;
              dcopy   = 17'(word[15:2]) + 17'd1;
            end else begin
              dm4 = {2'd0, instr_r[3], 14'd0} + 17'(word[15:2]);
              if (dm4 == 17'd0) begin
                if (last) fin_nxt = 1'b1;
                else fail_nxt = 1'b1;
              end else begin
                do_copy = 1'b1;
                dcopy   = dm4 + 17'h4000;
              end
            end
          end
          default: fail_nxt = 1'b1;
        endcase
        if (do_copy) begin
          if (dcopy == 17'd0 || (PW+1)'(dcopy) > (PW+1)'(prod_r)) begin
            fail_nxt = 1'b1;
          end else begin
            dist_nxt  = dcopy[15:0];
            phase_nxt = PH_COPY;
          end
        end
        if (last && !fin_nxt) fail_nxt = 1'b1;
      end
    end

    if (fail_nxt) begin
      emit       = 1'b0;
      s1_mem_nxt = 1'b0;
    end
    if (emit) begin
      wp_nxt = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (prod_r < PW'(HISTORY_DEPTH)) prod_nxt = prod_r + PW'(1);
    end
  end

  assign s1_ov_nxt  = emit;
  assign s1_lit_nxt = (emit && !s1_mem_nxt) ? in_data.packed_byte : 8'd0;
  assign s1_wr_nxt  = emit;
  // forward when the word leaving now writes the very entry this pull reads
  assign s1_fwd_nxt = s1_mem_nxt && leave && s1_wr_r && (s1_addr_r == rd_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      prod_r     <= '0;
      phase_r    <= PH_FIRST;
      instr_r    <= '0;
      run_r      <= '0;
      dist_r     <= '0;
      trail_r    <= '0;
      after_r    <= 1'b0;
      fin_r      <= 1'b0;
      fail_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        wp_r       <= wp_nxt;
        prod_r     <= prod_nxt;
        phase_r    <= phase_nxt;
        instr_r    <= instr_nxt;
        run_r      <= run_nxt;
        dist_r     <= dist_nxt;
        trail_r    <= trail_nxt;
        after_r    <= after_nxt;
        fin_r      <= fin_nxt;
        fail_r     <= fail_nxt;
        s1_valid_r <= 1'b1;
      end else if (leave) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // result payload; captured on accept, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ov_r   <= s1_ov_nxt;
      s1_lit_r  <= s1_lit_nxt;
      s1_mem_r  <= s1_mem_nxt;
      s1_fwd_r  <= s1_fwd_nxt;
      s1_wr_r   <= s1_wr_nxt;
      s1_addr_r <= wp_r;
      s1_pend_r <= !fail_nxt && !fin_nxt && (phase_nxt == PH_COPY);
      s1_stat_r <= fail_nxt ? ST_ERR : (fin_nxt ? ST_DONE : ST_RUN);
    end
    if (leave && s1_wr_r) begin
      last_wr_r <= s1_byte;
    end
  end

  assign s1_byte = s1_mem_r ? (s1_fwd_r ? last_wr_r : rdata) : s1_lit_r;

  lzo_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (leave && s1_wr_r),
    .waddr(s1_addr_r),
    .wdata(s1_byte),
    .re   (accept && s1_mem_nxt),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  assign out_valid             = s1_valid_r;
  assign out_data.out_valid    = s1_ov_r;
  assign out_data.out_byte     = s1_byte;
  assign out_data.copy_pending = s1_pend_r;
  assign out_data.status       = s1_stat_r;

  // a forwarded byte only ever feeds a copy
  a_fwd_is_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_fwd_r) |-> s1_mem_r)
    else $error("forward flag on a non-copy word");

  // an error is sticky
  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r |=> fail_r)
    else $error("error state cleared");

  // an emitted byte never comes with an error status
  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ov_r) |-> (s1_stat_r != ST_ERR))
    else $error("byte emitted on an errored word");

  // a stalled result holds its history write back
  a_hold_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_ready) |=> s1_valid_r)
    else $error("result dropped under stall");

endmodule

FILE: rtl/core/lzo_ram.sv
module lzo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
